### rtl/cfp_pkg.sv
package cfp_pkg;

  localparam logic [7:0] HDR_BYTE = 8'hFE;
  localparam logic [7:0] TRL_BYTE = 8'hFF;

  // Frame byte positions: 0 hunts for a header, 1..8 are stored, 9 is the trailer.
  localparam logic [3:0] POS_HUNT    = 4'd0;
  localparam logic [3:0] POS_FIRST   = 4'd1;
  localparam logic [3:0] POS_SUM_END = 4'd6;
  localparam logic [3:0] POS_STORE_END = 4'd8;
  localparam logic [3:0] POS_TRAILER = 4'd9;

  localparam logic [7:0] MODE_LINE  = 8'd0;
  localparam logic [7:0] MODE_RECOG = 8'd1;

  // raw * 180 / 2^9 gives 1/64 degree, raw * 15 / 2^5 gives 1/64 pixel.
  localparam int ANGLE_MUL  = 180;
  localparam int ANGLE_SH   = 9;
  localparam int OFFSET_MUL = 15;
  localparam int OFFSET_SH  = 5;

  localparam int OUT_W = 15;

  typedef logic [3:0] pos_t;

  typedef struct packed {
    logic        done;
    logic [7:0]  mode;
    logic [7:0]  target_class;
    logic [15:0] angle_word;
    logic [15:0] offset_word;
  } frame_t;

endpackage

### rtl/cfp_if.sv
interface cfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface cfp_result_if;
  logic              valid;
  logic              ready;
  logic [7:0]        mode;
  logic [7:0]        target_class;
  logic signed [14:0] heading_angle;
  logic signed [14:0] line_offset;

  modport source (output valid, output mode, output target_class,
                  output heading_angle, output line_offset, input ready);
  modport sink (input valid, input mode, input target_class,
                input heading_angle, input line_offset, output ready);
endinterface

### rtl/cfp_assembler.sv
module cfp_assembler (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            beat_en,
  input  logic [7:0]      rx_byte,
  output cfp_pkg::frame_t frame_o,
  output logic            at_trailer_o
);

  cfp_pkg::pos_t pos_r;
  cfp_pkg::pos_t pos_nxt;
  logic [15:0]   sum_r;
  logic [7:0]    store_r [8];
  logic [2:0]    store_idx;
  logic [3:0]    pos_less_one;

  assign pos_less_one = pos_r - cfp_pkg::POS_FIRST;
  assign store_idx    = pos_less_one[2:0];
  assign at_trailer_o = (pos_r == cfp_pkg::POS_TRAILER);

  always_comb begin
    pos_nxt = pos_r;
    if (beat_en) begin
      if (pos_r == cfp_pkg::POS_HUNT) begin
        if (rx_byte == cfp_pkg::HDR_BYTE) begin
          pos_nxt = cfp_pkg::POS_FIRST;
        end
      end else if (pos_r == cfp_pkg::POS_TRAILER) begin
        pos_nxt = cfp_pkg::POS_HUNT;
      end else begin
        pos_nxt = pos_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= cfp_pkg::POS_HUNT;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  // The running sum covers bytes 1..6 so the trailer only needs one compare.
  always_ff @(posedge clk) begin
    if (beat_en) begin
      if (pos_r == cfp_pkg::POS_HUNT) begin
        sum_r <= '0;
      end else if (pos_r inside {[cfp_pkg::POS_FIRST:cfp_pkg::POS_STORE_END]}) begin
        store_r[store_idx] <= rx_byte;
        if (pos_r inside {[cfp_pkg::POS_FIRST:cfp_pkg::POS_SUM_END]}) begin
          sum_r <= sum_r + {8'd0, rx_byte};
        end
      end
    end
  end

  always_comb begin
    frame_o.done = beat_en && at_trailer_o && (rx_byte == cfp_pkg::TRL_BYTE) &&
                   (sum_r == {store_r[6], store_r[7]});
    frame_o.mode         = store_r[0];
    frame_o.target_class = store_r[1];
    frame_o.angle_word   = {store_r[2], store_r[3]};
    frame_o.offset_word  = {store_r[4], store_r[5]};
  end

endmodule

### rtl/cfp_update.sv
module cfp_update (
  input  logic               clk,
  input  logic               rst_n,
  input  cfp_pkg::frame_t    frame_i,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [7:0]         mode,
  output logic [7:0]         target_class,
  output logic signed [14:0] heading_angle,
  output logic signed [14:0] line_offset
);

  logic               valid_r, valid_nxt;
  logic [7:0]         mode_r, mode_nxt;
  logic [7:0]         class_r, class_nxt;
  logic signed [14:0] angle_r, angle_nxt;
  logic signed [14:0] offset_r, offset_nxt;
  logic signed [23:0] angle_prod;
  logic signed [19:0] offset_prod;

  // Signed product, then an arithmetic shift by taking the upper bits.
  assign angle_prod  = $signed({{8{frame_i.angle_word[15]}}, frame_i.angle_word}) *
                       $signed(24'(cfp_pkg::ANGLE_MUL));
  assign offset_prod = $signed({{4{frame_i.offset_word[15]}}, frame_i.offset_word}) *
                       $signed(20'(cfp_pkg::OFFSET_MUL));

  always_comb begin
    valid_nxt  = valid_r && !out_ready;
    mode_nxt   = mode_r;
    class_nxt  = class_r;
    angle_nxt  = angle_r;
    offset_nxt = offset_r;
    if (frame_i.done) begin
      valid_nxt = 1'b1;
      mode_nxt  = frame_i.mode;
      if (frame_i.mode == cfp_pkg::MODE_LINE) begin
        angle_nxt  = angle_prod[cfp_pkg::ANGLE_SH +: cfp_pkg::OUT_W];
        offset_nxt = offset_prod[cfp_pkg::OFFSET_SH +: cfp_pkg::OUT_W];
      end else if (frame_i.mode == cfp_pkg::MODE_RECOG) begin
        class_nxt = frame_i.target_class;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      mode_r   <= '0;
      class_r  <= '0;
      angle_r  <= '0;
      offset_r <= '0;
    end else begin
      valid_r  <= valid_nxt;
      mode_r   <= mode_nxt;
      class_r  <= class_nxt;
      angle_r  <= angle_nxt;
      offset_r <= offset_nxt;
    end
  end

  assign out_valid     = valid_r;
  assign mode          = mode_r;
  assign target_class  = class_r;
  assign heading_angle = angle_r;
  assign line_offset   = offset_r;

endmodule

### rtl/camera_frame_parser.sv
// Camera frame parser.
// The in_ch channel carries one received byte per beat; the out_ch channel carries
// one result beat per good frame: the frame's mode plus the held class, heading
// angle (1/64 degree) and line offset (1/64 pixel).
// A frame is ten bytes: header 0xFE, mode, class, angle, offset, a 16-bit sum of
// bytes 1..6, and trailer 0xFF. Bytes other than 0xFE are skipped while hunting.
// A bad trailer or a checksum mismatch drops the frame without a result.
// Throughput is one byte per cycle. The result beat appears in the cycle after
// the trailer beat is taken; the checksum is summed as bytes arrive, so the
// trailer cycle holds only one compare and the angle and offset multipliers.
// Reset returns the parser to hunting, clears the held values to zero and empties
// the result register. When the receiver stalls, bytes keep flowing in; only the
// trailer beat waits (in_ch.ready low) while a result is still unclaimed.
module camera_frame_parser (
  input logic         clk,
  input logic         rst_n,
  cfp_byte_if.sink    in_ch,
  cfp_result_if.source out_ch
);

  cfp_pkg::frame_t frame;
  logic            at_trailer;
  logic            beat_en;

  // Only the trailer beat can produce a result, so it alone must find the
  // result register free or draining.
  assign in_ch.ready = !at_trailer || !out_ch.valid || out_ch.ready;
  assign beat_en     = in_ch.valid && in_ch.ready;

  cfp_assembler u_assembler (
    .clk          (clk),
    .rst_n        (rst_n),
    .beat_en      (beat_en),
    .rx_byte      (in_ch.rx_byte),
    .frame_o      (frame),
    .at_trailer_o (at_trailer)
  );

  // The held values double as the result register; they change only when a
  // result is issued, which happens only after the previous one was taken.
  cfp_update u_update (
    .clk           (clk),
    .rst_n         (rst_n),
    .frame_i       (frame),
    .out_ready     (out_ch.ready),
    .out_valid     (out_ch.valid),
    .mode          (out_ch.mode),
    .target_class  (out_ch.target_class),
    .heading_angle (out_ch.heading_angle),
    .line_offset   (out_ch.line_offset)
  );

`ifndef SYNTHESIS
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready && at_trailer) |-> !in_ch.ready)
    else $error("trailer accepted while a result is pending");

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.heading_angle >= -15'sd11520 &&
                      out_ch.heading_angle <= 15'sd11519))
    else $error("heading angle out of range");

  a_offset_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.line_offset >= -15'sd15360 &&
                      out_ch.line_offset <= 15'sd15359))
    else $error("line offset out of range");

  a_issue_after_frame: assert property (@(posedge clk) disable iff (!rst_n)
    frame.done |=> out_ch.valid)
    else $error("good frame did not issue a result");
`endif

endmodule

### test/tb.sv
`timescale 1ns / 100ps

// Testbench for the camera frame parser.
// A byte queue is filled with link traffic before reset is released: a few
// hand-picked frames first, then randomly built frames mixed with noise and
// broken frames. A clocked driver offers the bytes on in_ch with random gaps,
// and a clocked receiver takes results on out_ch with random stalls.
// Every byte that is accepted is run through a local frame parser, which pushes
// the expected result beat for each good frame. The monitor compares every
// result beat, field by field, with the oldest expected beat.
module tb;

  // Percentage of cycles in which either side idles outside the quiet window.
  localparam int IDLE_PCT    = 21;
  // Lower bound on the bytes that belong to random frames (noise is not counted).
  localparam int FRAME_BYTES = 600;
  // Receiver hold-off length, started once a few results have arrived.
  localparam int HOLD_LEN    = 250;
  localparam int HOLD_AFTER  = 6;
  localparam int CYCLE_LIMIT = 100000;

  typedef struct packed {
    logic [7:0]         mode;
    logic [7:0]         target_class;
    logic signed [14:0] heading_angle;
    logic signed [14:0] line_offset;
  } result_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  cfp_byte_if   in_ch ();
  cfp_result_if out_ch ();

  camera_frame_parser DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bytes still to be sent on the link, and results still to arrive.
  logic [7:0] link_bytes[$];
  result_t    expected_results[$];

  int bytes_total  = 0;
  int bytes_taken  = 0;
  int results_seen = 0;
  int fail_count   = 0;
  int cycle_cnt    = 0;
  int hold_cycles  = 0;
  bit hold_done    = 1'b0;
  bit byte_taken   = 1'b0;

  // No random idling inside this window; only the receiver hold-off can stall.
  wire quiet_window = (cycle_cnt >= 400) && (cycle_cnt < 700);

  // Local copy of the parser state.
  cfp_pkg::pos_t      frame_pos;
  logic [7:0]         frame_bytes[8];
  logic [7:0]         held_mode;
  logic [7:0]         held_class;
  logic signed [14:0] held_angle;
  logic signed [14:0] held_offset;

  // Scales a signed 16-bit word by mul / 2^sh, rounding toward minus infinity.
  function automatic logic signed [14:0] scale_fixed(logic [15:0] word, int mul, int sh);
    int prod;
    prod = $signed(word);
    prod = (prod * mul) >>> sh;
    return prod[14:0];
  endfunction

  // Advances the local parser by one accepted byte. When the trailer closes a
  // frame with a good checksum, the expected result beat is queued.
  task automatic parse_byte(input logic [7:0] b);
    logic [15:0] sum;
    result_t     res;
    if (frame_pos == cfp_pkg::POS_HUNT) begin
      // Anything but a header is dropped while hunting.
      if (b == cfp_pkg::HDR_BYTE) frame_pos = cfp_pkg::POS_FIRST;
    end else if (frame_pos == cfp_pkg::POS_TRAILER) begin
      frame_pos = cfp_pkg::POS_HUNT;
      sum = 16'h0000;
      for (int i = 0; i < 6; i++) sum = sum + 16'(frame_bytes[i]);
      if (b == cfp_pkg::TRL_BYTE && sum == {frame_bytes[6], frame_bytes[7]}) begin
        held_mode = frame_bytes[0];
        if (held_mode == cfp_pkg::MODE_LINE) begin
          held_angle  = scale_fixed({frame_bytes[2], frame_bytes[3]},
                                    cfp_pkg::ANGLE_MUL, cfp_pkg::ANGLE_SH);
          held_offset = scale_fixed({frame_bytes[4], frame_bytes[5]},
                                    cfp_pkg::OFFSET_MUL, cfp_pkg::OFFSET_SH);
        end else if (held_mode == cfp_pkg::MODE_RECOG) begin
          held_class = frame_bytes[1];
        end
        res.mode          = held_mode;
        res.target_class  = held_class;
        res.heading_angle = held_angle;
        res.line_offset   = held_offset;
        expected_results.push_back(res);
      end
    end else begin
      // A header byte in the middle of a frame is plain data.
      frame_bytes[frame_pos - cfp_pkg::POS_FIRST] = b;
      frame_pos = frame_pos + 4'd1;
    end
  endtask

  // Appends one complete frame to the link. A bad checksum is made by flipping
  // a random nonzero pattern into the correct sum.
  task automatic add_frame(input logic [7:0] mode, input logic [7:0] cls,
                           input logic [15:0] angle_word, input logic [15:0] offset_word,
                           input bit sum_ok, input logic [7:0] trailer);
    logic [15:0] sum;
    sum = 16'(mode) + 16'(cls) + 16'(angle_word[15:8]) + 16'(angle_word[7:0])
        + 16'(offset_word[15:8]) + 16'(offset_word[7:0]);
    if (!sum_ok) sum = sum ^ 16'($urandom_range(1, 65535));
    link_bytes.push_back(cfp_pkg::HDR_BYTE);
    link_bytes.push_back(mode);
    link_bytes.push_back(cls);
    link_bytes.push_back(angle_word[15:8]);
    link_bytes.push_back(angle_word[7:0]);
    link_bytes.push_back(offset_word[15:8]);
    link_bytes.push_back(offset_word[7:0]);
    link_bytes.push_back(sum[15:8]);
    link_bytes.push_back(sum[7:0]);
    link_bytes.push_back(trailer);
  endtask

  // Random word that lands on the range ends or on zero now and then.
  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Builds all link traffic. Random frames are mostly well formed so that the
  // parser reaches the trailer check often; the rest are noise bytes, frames
  // cut short, bad checksums and bad trailers.
  task automatic build_traffic();
    int         sent;
    int         pick;
    int         cut;
    logic [7:0] mode;
    sent = 0;

    // Noise while hunting, including a trailer byte with no frame around it.
    link_bytes.push_back(8'h00);
    link_bytes.push_back(cfp_pkg::TRL_BYTE);
    // Line frame at the negative angle end and the positive offset end.
    add_frame(cfp_pkg::MODE_LINE, 8'h5A, 16'h8000, 16'h7FFF, 1'b1, cfp_pkg::TRL_BYTE);
    // Recognition frame whose class byte equals the header byte.
    add_frame(cfp_pkg::MODE_RECOG, cfp_pkg::HDR_BYTE, 16'h7FFF, 16'h8000, 1'b1,
              cfp_pkg::TRL_BYTE);
    // Good sum but a wrong trailer: dropped.
    add_frame(cfp_pkg::MODE_LINE, 8'h00, 16'h7FFF, 16'h8000, 1'b1, cfp_pkg::HDR_BYTE);
    // Right trailer but a wrong sum: dropped.
    add_frame(cfp_pkg::MODE_LINE, 8'hFF, 16'hFFFF, 16'h0001, 1'b0, cfp_pkg::TRL_BYTE);
    // Unknown mode: only the mode moves.
    add_frame(8'hFF, 8'h00, 16'h0000, 16'hFFFF, 1'b1, cfp_pkg::TRL_BYTE);
    // Line frame at the positive angle end and the negative offset end.
    add_frame(cfp_pkg::MODE_LINE, 8'hA5, 16'h7FFF, 16'h8000, 1'b1, cfp_pkg::TRL_BYTE);

    while (sent < FRAME_BYTES) begin
      if ($urandom_range(0, 99) < 15) begin
        repeat ($urandom_range(1, 3)) link_bytes.push_back(8'($urandom_range(0, 255)));
      end
      pick = $urandom_range(0, 99);
      if (pick < 45) mode = cfp_pkg::MODE_LINE;
      else if (pick < 75) mode = cfp_pkg::MODE_RECOG;
      else mode = 8'($urandom_range(2, 255));
      if ($urandom_range(0, 99) < 6) begin
        // Frame cut short; the bytes that follow are read as its remainder.
        cut = $urandom_range(1, 8);
        link_bytes.push_back(cfp_pkg::HDR_BYTE);
        repeat (cut) link_bytes.push_back(8'($urandom_range(0, 255)));
        sent += cut + 1;
      end else begin
        add_frame(mode, 8'($urandom_range(0, 255)), pick_word(), pick_word(),
                  $urandom_range(0, 99) < 88,
                  ($urandom_range(0, 99) < 92) ? cfp_pkg::TRL_BYTE
                                               : 8'($urandom_range(0, 254)));
        sent += 10;
      end
    end
  endtask

  // Sender: at each falling edge it either holds an unaccepted beat, offers the
  // next byte, or idles.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || byte_taken) begin
      if (link_bytes.size() != 0 && (quiet_window || $urandom_range(0, 99) >= IDLE_PCT)) begin
        in_ch.valid   <= 1'b1;
        in_ch.rx_byte <= link_bytes.pop_front();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
    byte_taken = 1'b0;
  end

  // Byte beats are taken at the rising edge and fed to the local parser.
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      parse_byte(in_ch.rx_byte);
      byte_taken = 1'b1;
      bytes_taken++;
    end
  end

  // Receiver: random stalls, plus one long hold-off counted here, during which
  // the sender keeps offering bytes until the block stalls at a trailer.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_cycles != 0) begin
      out_ch.ready <= 1'b0;
      hold_cycles = hold_cycles - 1;
    end else if (!hold_done && results_seen >= HOLD_AFTER) begin
      hold_done = 1'b1;
      hold_cycles = HOLD_LEN - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= quiet_window || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Result monitor: each result beat must match the oldest expected beat.
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $display("%0t: result beat with none expected, actual mode=%0d class=%0d %s%0d %s%0d",
                 $time, out_ch.mode, out_ch.target_class, "angle=", out_ch.heading_angle,
                 "offset=", out_ch.line_offset);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("mode", want.mode, out_ch.mode);
        check_field("target_class", want.target_class, out_ch.target_class);
        check_field("heading_angle", want.heading_angle, out_ch.heading_angle);
        check_field("line_offset", want.line_offset, out_ch.line_offset);
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = 8'h00;
    out_ch.ready  = 1'b0;

    // The local parser starts hunting with all held values at zero.
    frame_pos   = cfp_pkg::POS_HUNT;
    held_mode   = 8'h00;
    held_class  = 8'h00;
    held_angle  = 15'sd0;
    held_offset = 15'sd0;
    for (int i = 0; i < 8; i++) frame_bytes[i] = 8'h00;

    build_traffic();
    bytes_total = link_bytes.size();

    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // Drain: every byte accepted, every expected result delivered, then a few
    // cycles more so that a stray late result would still be caught.
    while (bytes_taken != bytes_total) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
